@@ design/rle_pkg.sv @@
// Shared types and constants for the run-length symbol expander.
// No dependencies; imported by rle_ctrl, rle_dp and rle_symbol_run_expander.
`default_nettype none

package rle_pkg;

    localparam int RLE_MAX_RUN = 64;

    localparam int CHAR_W  = 8;
    localparam int GROUP_W = 5;

    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;

    localparam logic [GROUP_W-1:0] UPPER_BASE = 5'd26;
    localparam int                 DEC_BASE   = 10;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } rle_state_t;

    typedef struct packed {
        logic accept;
        logic step;
    } rle_cmd_t;

    typedef struct packed {
        logic out_free;
        logic run_start;
        logic last_group;
    } rle_status_t;

endpackage

`default_nettype wire

@@ design/rle_ctrl.sv @@
// Controller state machine: takes one transaction in, then emits any run it completes.
// Depends on rle_pkg; drives command signals into rle_dp.
`default_nettype none

module rle_ctrl
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  rle_pkg::rle_status_t  sts,
    output rle_pkg::rle_cmd_t     cmd
);
    import rle_pkg::*;

    rle_state_t state_reg;
    rle_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = sts.out_free;
                if (in_valid && sts.out_free)
                begin
                    cmd.accept = 1'b1;
                    if (sts.run_start)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.step = 1'b1;
                    if (sts.last_group)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/rle_dp.sv @@
// Datapath: character decode, run count accumulation, run emission and output register.
// Depends on rle_pkg; steered by rle_ctrl through rle_cmd_t / rle_status_t.
`default_nettype none

module rle_dp
#(
    parameter int MAX_RUN = rle_pkg::RLE_MAX_RUN
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire  [rle_pkg::CHAR_W-1:0]       char_byte,
    input  wire                              end_of_stream,
    input  rle_pkg::rle_cmd_t                cmd,
    output rle_pkg::rle_status_t             sts,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [rle_pkg::GROUP_W-1:0]      bit_group,
    output logic                             last_of_run,
    output logic                             invalid_char,
    output logic                             run_truncated
);
    import rle_pkg::*;

    localparam int CNT_W  = $clog2(MAX_RUN + 1);
    localparam int PROD_W = CNT_W + 4;

    // decoder state
    logic [GROUP_W-1:0] pending_symbol_reg, pending_symbol_next;
    logic               symbol_valid_reg,   symbol_valid_next;
    logic [CNT_W-1:0]   run_count_reg,      run_count_next;
    logic               count_saturated_reg, count_saturated_next;
    logic               error_mode_reg,     error_mode_next;

    // run being emitted
    logic [GROUP_W-1:0] emit_sym_reg,  emit_sym_next;
    logic [CNT_W-1:0]   emit_left_reg, emit_left_next;
    logic               emit_sat_reg,  emit_sat_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [GROUP_W-1:0] group_reg,     group_next;
    logic               last_reg,      last_next;
    logic               inv_reg,       inv_next;
    logic               trunc_reg,     trunc_next;

    logic               is_lower, is_upper, is_digit, is_letter;
    logic [CHAR_W-1:0]  off_lower, off_upper, off_digit;
    logic [GROUP_W-1:0] letter_sym;
    logic [CNT_W-1:0]   flush_n;
    logic [PROD_W-1:0]  count_acc;

    always_comb
    begin
        is_lower  = (char_byte >= CH_LOWER_A) && (char_byte <= CH_LOWER_Z);
        is_upper  = (char_byte >= CH_UPPER_A) && (char_byte <= CH_UPPER_F);
        is_digit  = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
        is_letter = is_lower || is_upper;
        off_lower = char_byte - CH_LOWER_A;
        off_upper = char_byte - CH_UPPER_A;
        off_digit = char_byte - CH_ZERO;
        letter_sym = is_lower ? off_lower[GROUP_W-1:0]
                              : off_upper[GROUP_W-1:0] + UPPER_BASE;
        flush_n   = symbol_valid_reg ? run_count_reg : '0;
        count_acc = {4'b0, run_count_reg} * PROD_W'(DEC_BASE)
                  + PROD_W'(off_digit[3:0]);
    end

    always_comb
    begin
        sts.out_free   = !out_valid_reg || out_ready;
        sts.run_start  = !error_mode_reg && (end_of_stream || is_letter)
                       && (flush_n != '0);
        sts.last_group = (emit_left_reg == CNT_W'(1));
    end

    always_comb
    begin
        pending_symbol_next  = pending_symbol_reg;
        symbol_valid_next    = symbol_valid_reg;
        run_count_next       = run_count_reg;
        count_saturated_next = count_saturated_reg;
        error_mode_next      = error_mode_reg;
        emit_sym_next        = emit_sym_reg;
        emit_left_next       = emit_left_reg;
        emit_sat_next        = emit_sat_reg;
        out_valid_next       = out_valid_reg && !out_ready;
        group_next           = group_reg;
        last_next            = last_reg;
        inv_next             = inv_reg;
        trunc_next           = trunc_reg;

        if (cmd.accept)
        begin
            if (sts.run_start)
            begin
                emit_sym_next  = pending_symbol_reg;
                emit_left_next = flush_n;
                emit_sat_next  = count_saturated_reg;
            end
            priority if (end_of_stream)
            begin
                pending_symbol_next  = '0;
                symbol_valid_next    = 1'b0;
                run_count_next       = '0;
                count_saturated_next = 1'b0;
                error_mode_next      = 1'b0;
            end
            else if (error_mode_reg)
            begin
                error_mode_next = 1'b1;
            end
            else if (is_letter)
            begin
                pending_symbol_next  = letter_sym;
                symbol_valid_next    = 1'b1;
                run_count_next       = '0;
                count_saturated_next = 1'b0;
            end
            else if (is_digit && symbol_valid_reg)
            begin
                if (count_acc > PROD_W'(MAX_RUN))
                begin
                    run_count_next       = CNT_W'(MAX_RUN);
                    count_saturated_next = 1'b1;
                end
                else
                begin
                    run_count_next = count_acc[CNT_W-1:0];
                end
            end
            else
            begin
                pending_symbol_next  = '0;
                symbol_valid_next    = 1'b0;
                run_count_next       = '0;
                count_saturated_next = 1'b0;
                error_mode_next      = 1'b1;
                out_valid_next       = 1'b1;
                group_next           = '0;
                last_next            = 1'b1;
                inv_next             = 1'b1;
                trunc_next           = 1'b0;
            end
        end

        if (cmd.step)
        begin
            emit_left_next = emit_left_reg - CNT_W'(1);
            out_valid_next = 1'b1;
            group_next     = emit_sym_reg;
            last_next      = sts.last_group;
            inv_next       = 1'b0;
            trunc_next     = sts.last_group && emit_sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_symbol_reg  <= '0;
            symbol_valid_reg    <= 1'b0;
            run_count_reg       <= '0;
            count_saturated_reg <= 1'b0;
            error_mode_reg      <= 1'b0;
            emit_left_reg       <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            pending_symbol_reg  <= pending_symbol_next;
            symbol_valid_reg    <= symbol_valid_next;
            run_count_reg       <= run_count_next;
            count_saturated_reg <= count_saturated_next;
            error_mode_reg      <= error_mode_next;
            emit_left_reg       <= emit_left_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        emit_sym_reg <= emit_sym_next;
        emit_sat_reg <= emit_sat_next;
        group_reg    <= group_next;
        last_reg     <= last_next;
        inv_reg      <= inv_next;
        trunc_reg    <= trunc_next;
    end

    assign out_valid     = out_valid_reg;
    assign bit_group     = group_reg;
    assign last_of_run   = last_reg;
    assign invalid_char  = inv_reg;
    assign run_truncated = trunc_reg;

    a_step_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> emit_left_reg != '0)
        else $error("group emitted with no run left");

    a_error_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && inv_reg |-> last_reg && !trunc_reg && group_reg == '0)
        else $error("malformed error result");

    a_run_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && sts.run_start |=> emit_left_reg != '0)
        else $error("run started with zero count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_count_reg <= CNT_W'(MAX_RUN))
        else $error("run count above maximum");

endmodule

`default_nettype wire

@@ design/rle_symbol_run_expander.sv @@
// On acceptance, a completed run is loaded into the emit counter; an error result goes
// straight to the output register. No new item is taken while a run is emitted by the
// single emit counter, one group a cycle into the output register while it is free.
// Reset: rst_n asynchronous, active low; clears decode state, no clearing pass.
// Top level of the run-length symbol expander; depends on rle_pkg, rle_ctrl, rle_dp.
`default_nettype none

module rle_symbol_run_expander
#(
    parameter int MAX_RUN = rle_pkg::RLE_MAX_RUN
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  [rle_pkg::CHAR_W-1:0]       char_byte,
    input  wire                              end_of_stream,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [rle_pkg::GROUP_W-1:0]      bit_group,
    output logic                             last_of_run,
    output logic                             invalid_char,
    output logic                             run_truncated
);
    import rle_pkg::*;

    rle_cmd_t    cmd;
    rle_status_t sts;

    rle_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rle_dp
    #(
        .MAX_RUN (MAX_RUN)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_byte     (char_byte),
        .end_of_stream (end_of_stream),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .bit_group     (bit_group),
        .last_of_run   (last_of_run),
        .invalid_char  (invalid_char),
        .run_truncated (run_truncated)
    );

endmodule

`default_nettype wire
